>>> rtl/core/rfb_pkg.sv
// Shared types, register indexes and the quality-code table for the record frame builder.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package rfb_pkg;

	localparam int NUM_BYTES  = 13;
	localparam int CNT_W      = 4;
	localparam int HDR_BYTES  = 4;
	localparam int REC_BYTES  = 7;

	typedef logic [7:0]             byte_t;
	typedef logic [CNT_W-1:0]       bcnt_t;
	typedef byte_t [NUM_BYTES-1:0]  frame_bytes_t;

	// Configuration register indexes
	localparam logic [1:0] REG_RECORD_COUNT = 2'd0;
	localparam logic [1:0] REG_START_BYTE   = 2'd1;
	localparam logic [1:0] REG_END_BYTE     = 2'd2;

	// Configuration reset values
	localparam byte_t RST_RECORD_COUNT = 8'd1;
	localparam byte_t RST_START_BYTE   = 8'd2;
	localparam byte_t RST_END_BYTE     = 8'd3;

	// Word counts per burst shape
	localparam bcnt_t NB_MID   = 4'd7;
	localparam bcnt_t NB_LAST  = 4'd9;
	localparam bcnt_t NB_FIRST = 4'd11;
	localparam bcnt_t NB_BOTH  = 4'd13;

	// Raw quality decoding
	localparam logic [15:0] Q_MAJOR_MASK = 16'h00C0;
	localparam logic [15:0] Q_GOOD       = 16'h00C0;
	localparam logic [15:0] Q_UNCERTAIN  = 16'h0040;
	localparam logic [15:0] Q_BAD_A      = 16'h0008;
	localparam logic [15:0] Q_BAD_B      = 16'h0018;
	localparam logic [15:0] Q_BAD_C      = 16'h000C;
	localparam logic [15:0] Q_BAD_D      = 16'h0010;

	localparam byte_t CODE_GOOD      = 8'd0;
	localparam byte_t CODE_UNCERTAIN = 8'd1;
	localparam byte_t CODE_BAD_A     = 8'd2;
	localparam byte_t CODE_BAD_B     = 8'd3;
	localparam byte_t CODE_BAD_C     = 8'd4;
	localparam byte_t CODE_BAD_D     = 8'd5;
	localparam byte_t CODE_OTHER     = 8'd9;

	typedef struct packed {
		logic        [15:0] tag_id;
		logic        [15:0] raw_quality;
		logic signed [31:0] sample_value;
	} record_t;

	typedef struct packed {
		byte_t record_count;
		byte_t start_byte;
		byte_t end_byte;
	} cfg_t;

	// One record's worth of output words, first word in element 0
	typedef struct packed {
		frame_bytes_t bytes;
		bcnt_t        nbytes;
		logic         closes;
	} burst_t;

	function automatic byte_t quality_code(input logic [15:0] q);
		byte_t code;
		priority if ((q & Q_MAJOR_MASK) == Q_GOOD)      code = CODE_GOOD;
		else if ((q & Q_MAJOR_MASK) == Q_UNCERTAIN)     code = CODE_UNCERTAIN;
		else if (q == Q_BAD_A)                          code = CODE_BAD_A;
		else if (q == Q_BAD_B)                          code = CODE_BAD_B;
		else if (q == Q_BAD_C)                          code = CODE_BAD_C;
		else if (q == Q_BAD_D)                          code = CODE_BAD_D;
		else                                            code = CODE_OTHER;
		return code;
	endfunction

endpackage

>>> rtl/core/rfb_in_reg.sv
// Input holding register for the record frame builder.
// Depends on rfb_pkg (record_t).
`timescale 1ns / 1ps

module rfb_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  rfb_pkg::record_t rec_in,
	input  logic            take,
	output logic            full,
	output rfb_pkg::record_t rec_out
);
	import rfb_pkg::*;

	logic    full_q;
	record_t rec_q;
	logic    accept;

	// Refill in the same cycle the held word moves on
	assign in_stall = full_q & ~take;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else begin
			full_q <= accept | (full_q & ~take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q <= rec_in;
		end
	end

	assign full    = full_q;
	assign rec_out = rec_q;

endmodule

>>> rtl/core/rfb_encode.sv
// Frame encoder: turns one record into its burst of frame words and keeps the
// per-frame record count and running checksum. Depends on rfb_pkg.
`timescale 1ns / 1ps

module rfb_encode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rfb_pkg::record_t rec,
	input  rfb_pkg::cfg_t    cfg,
	output rfb_pkg::burst_t  burst
);
	import rfb_pkg::*;

	byte_t        records_done_q;
	byte_t        running_xor_q;
	byte_t        count;
	logic [15:0]  len;
	logic         first;
	logic         closes;
	byte_t        hdr [HDR_BYTES];
	byte_t        rb  [REC_BYTES];
	byte_t        xsum;
	frame_bytes_t bytes;

	always_comb begin
		count  = (cfg.record_count == 8'd0) ? 8'd1 : cfg.record_count;
		// 1 + 7*count as (count << 3) - count
		len    = 16'd1 + {5'd0, count, 3'd0} - {8'd0, count};
		first  = (records_done_q == 8'd0);
		closes = ({1'b0, records_done_q} + 9'd1) >= {1'b0, count};

		hdr[0] = cfg.start_byte;
		hdr[1] = len[7:0];
		hdr[2] = len[15:8];
		hdr[3] = count;

		rb[0] = rec.tag_id[7:0];
		rb[1] = rec.tag_id[15:8];
		rb[2] = quality_code(rec.raw_quality);
		rb[3] = rec.sample_value[7:0];
		rb[4] = rec.sample_value[15:8];
		rb[5] = rec.sample_value[23:16];
		rb[6] = rec.sample_value[31:24];

		// Start marker stays out of the checksum
		xsum = first ? (hdr[1] ^ hdr[2] ^ hdr[3]) : running_xor_q;
		for (int i = 0; i < REC_BYTES; i++) begin
			xsum = xsum ^ rb[i];
		end

		bytes = '0;
		if (first) begin
			for (int i = 0; i < HDR_BYTES; i++) begin
				bytes[i] = hdr[i];
			end
			for (int i = 0; i < REC_BYTES; i++) begin
				bytes[HDR_BYTES + i] = rb[i];
			end
			if (closes) begin
				bytes[HDR_BYTES + REC_BYTES]     = xsum;
				bytes[HDR_BYTES + REC_BYTES + 1] = cfg.end_byte;
			end
		end else begin
			for (int i = 0; i < REC_BYTES; i++) begin
				bytes[i] = rb[i];
			end
			if (closes) begin
				bytes[REC_BYTES]     = xsum;
				bytes[REC_BYTES + 1] = cfg.end_byte;
			end
		end

		burst.bytes  = bytes;
		burst.closes = closes;
		unique case ({first, closes})
			2'b00:   burst.nbytes = NB_MID;
			2'b01:   burst.nbytes = NB_LAST;
			2'b10:   burst.nbytes = NB_FIRST;
			default: burst.nbytes = NB_BOTH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			records_done_q <= 8'd0;
			running_xor_q  <= 8'd0;
		end else if (load) begin
			records_done_q <= closes ? 8'd0 : records_done_q + 8'd1;
			running_xor_q  <= closes ? 8'd0 : xsum;
		end
	end

endmodule

>>> rtl/core/rfb_serializer.sv
// Output serializer: holds one burst and shifts it out one word per cycle
// while out_stall is low. Depends on rfb_pkg (burst_t, frame_bytes_t).
`timescale 1ns / 1ps

module rfb_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  rfb_pkg::burst_t burst,
	output logic            free,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      frame_byte,
	output logic            frame_end
);
	import rfb_pkg::*;

	bcnt_t        cnt_q;
	frame_bytes_t bytes_q;
	logic         closes_q;
	logic         take;

	assign take       = (cnt_q != '0) & ~out_stall;
	assign free       = (cnt_q == '0) | ((cnt_q == bcnt_t'(1)) & take);
	assign out_valid  = (cnt_q != '0);
	assign frame_byte = bytes_q[0];
	assign frame_end  = closes_q & (cnt_q == bcnt_t'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.nbytes;
		end else if (take) begin
			cnt_q <= cnt_q - bcnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst.bytes;
			closes_q <= burst.closes;
		end else if (take) begin
			for (int i = 0; i < NUM_BYTES - 1; i++) begin
				bytes_q[i] <= bytes_q[i + 1];
			end
		end
	end

endmodule

>>> rtl/core/record_frame_builder_top.sv
// Top level of the record frame builder: configuration registers, input holding
// register, frame encoder and output serializer. Depends on rfb_pkg, rfb_in_reg,
// rfb_encode and rfb_serializer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one record per word: tag_id,
//   raw_quality and sample_value. Output channel (out_valid / out_stall)
//   carries the frame one byte per word in frame_byte; frame_end marks the end
//   marker. The first record of a frame is preceded by the start marker, the
//   little-endian length 1 + 7*count and the count; the record that completes
//   the frame is followed by the XOR checksum and the end marker.
//   With the serializer empty, a taken record passes from the input holding
//   register into the serializer, which then presents its first byte.
//   The serializer sends one byte per cycle while out_stall is low; a record's
//   burst is 7 bytes in mid-frame, 11 when it opens a frame, 9 when it closes
//   one and 13 when it does both. The input register takes the next record
//   while the current burst is still shifting out.
//   Reset clears the frame state (no frame open, checksum zero), empties both
//   registers and sets record_count = 1, start_byte = 2, end_byte = 3.
//   When the receiver stalls, the current byte holds and the input side
//   stalls once its holding register is full. Configuration (cfg_we / cfg_index /
//   cfg_data) must be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module record_frame_builder_top (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	// record input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        tag_id,
	input  logic [15:0]        raw_quality,
	input  logic signed [31:0] sample_value,
	// frame byte output
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         frame_byte,
	output logic               frame_end
);
	import rfb_pkg::*;

	cfg_t    cfg_q;
	record_t rec_in;
	record_t rec_held;
	burst_t  burst;
	logic    in_full;
	logic    ser_free;
	logic    load;

	// Configuration registers; writes to an unused index are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.record_count <= RST_RECORD_COUNT;
			cfg_q.start_byte   <= RST_START_BYTE;
			cfg_q.end_byte     <= RST_END_BYTE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RECORD_COUNT: cfg_q.record_count <= cfg_data;
				REG_START_BYTE:   cfg_q.start_byte   <= cfg_data;
				REG_END_BYTE:     cfg_q.end_byte     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rec_in.tag_id       = tag_id;
	assign rec_in.raw_quality  = raw_quality;
	assign rec_in.sample_value = sample_value;

	// Advance a held record once the serializer is empty or its last byte is leaving
	assign load = in_full & ser_free;

	rfb_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rec_in   (rec_in),
		.take     (load),
		.full     (in_full),
		.rec_out  (rec_held)
	);

	rfb_encode u_encode (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.rec    (rec_held),
		.cfg    (cfg_q),
		.burst  (burst)
	);

	rfb_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.burst      (burst),
		.free       (ser_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.frame_end  (frame_end)
	);

	// A loaded burst always has one of the four legal shapes
	a_burst_shape: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (burst.nbytes == NB_MID || burst.nbytes == NB_LAST ||
			burst.nbytes == NB_FIRST || burst.nbytes == NB_BOTH))
		else $error("burst length not 7, 9, 11 or 13");

	// A load is always followed by a byte on the output
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded burst not presented");

	// Input side stalls only while a record is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_full)
		else $error("input stalled with empty holding register");

	// End marker comes only from a burst that closes a frame, and only as its last byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end && !out_stall && !load) |=> !out_valid)
		else $error("bytes remain after end marker");

endmodule
